// ===== rtl/hit_pkg.sv =====
// shared types and constants of the handle intern table
package hit_pkg;

	// default table depth
	localparam int unsigned SLOTS_DEF = 256;

	// first integer handed out for an interned handle
	localparam logic [31:0] INTERN_BASE = 32'h4000_0000;

	// register reset values
	localparam logic [15:0] PREDEF_LOW_RST  = 16'h0020;
	localparam logic [15:0] PREDEF_HIGH_RST = 16'h02eb;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PREDEF_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREDEF_HIGH = 2'd1;

	// conversion modes
	localparam logic MODE_SERIALIZE   = 1'b0;
	localparam logic MODE_DESERIALIZE = 1'b1;

	// request transaction
	typedef struct packed {
		logic               mode;
		logic [63:0]        handle_bits;
		logic signed [31:0] int_value;
	} req_t;

	// response transaction
	typedef struct packed {
		logic signed [31:0] int_result;
		logic [63:0]        handle_result;
		logic               success;
	} rsp_t;

endpackage

// ===== rtl/handle_intern_table.sv =====
// Handle intern table top level: maps 64-bit handles to small integers and back.
// A request carries a mode, a handle and an integer; every request gives exactly one
// response. Serialize returns passthrough values and rejects a zero handle without a scan;
// otherwise it scans the filled entries of the entry memory one per cycle through its
// single read port, then appends on a miss while the table is not full. Deserialize of a
// slot value is one memory read; passthrough and rejected values use none. One request
// is in flight at a time; a finished response waits in the output register while the next
// request is accepted. Entries at or beyond the fill count read as empty, so no clearing
// pass follows reset. The predefined range registers may be written at any time through
// the configuration port and take effect for the next request.
module handle_intern_table import hit_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RDW  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [15:0]      predef_low_q;
	logic [15:0]      predef_high_q;
	logic [63:0]      handle_q;
	logic [CNT_W-1:0] issue_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             req_acc;
	logic             rsp_load;
	logic             ser_predef;
	logic             des_predef;
	logic [29:0]      des_off;
	logic             des_slot;
	logic             scan_hit;
	logic             scan_done;
	logic             table_full;
	logic             wr_en;
	logic [IDX_W-1:0] rd_addr;
	logic [63:0]      rd_data;

	// handshake
	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// request decode
	assign ser_predef = (req.handle_bits >= {48'b0, predef_low_q})
		&& (req.handle_bits <= {48'b0, predef_high_q});
	assign des_predef = !req.int_value[31]
		&& ($unsigned(req.int_value) >= {16'b0, predef_low_q})
		&& ($unsigned(req.int_value) <= {16'b0, predef_high_q});
	assign des_off    = req.int_value[29:0];
	assign des_slot   = (req.int_value[31:30] == 2'b01) && (des_off < 30'(fill_q));

	// scan control
	assign scan_hit   = cmp_vld_s1 && (rd_data == handle_q);
	assign scan_done  = !cmp_vld_s1 && (issue_q == fill_q);
	assign table_full = (fill_q == CNT_W'(SLOTS));
	assign wr_en      = (state_q == ST_SCAN) && scan_done && !table_full;
	assign rd_addr    = (state_q == ST_IDLE) ? des_off[IDX_W-1:0] : issue_q[IDX_W-1:0];

	hit_ram #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (handle_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predef_low_q  <= PREDEF_LOW_RST;
			predef_high_q <= PREDEF_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PREDEF_LOW:  predef_low_q  <= cfg_data;
				REG_PREDEF_HIGH: predef_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (req_acc) begin
						if (req.mode == MODE_SERIALIZE) begin
							state_q <= (ser_predef || req.handle_bits == 64'b0) ?
								ST_FIN : ST_SCAN;
						end else begin
							state_q <= (!des_predef && des_slot) ? ST_RDW : ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= (issue_q < fill_q);
					if (scan_hit || scan_done) begin
						state_q <= ST_FIN;
					end
					if (wr_en) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				ST_RDW: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: handle, scan pointers and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				handle_q <= req.handle_bits;
				issue_q  <= '0;
				if (req.mode == MODE_SERIALIZE && ser_predef) begin
					res_q <= {req.handle_bits[31:0], 64'b0, 1'b1};
				end else if (req.mode == MODE_DESERIALIZE && des_predef) begin
					res_q <= {32'b0, 32'b0, req.int_value, 1'b1};
				end else begin
					res_q <= '0;
				end
			end
			ST_SCAN: begin
				if (issue_q < fill_q) begin
					issue_q    <= issue_q + CNT_W'(1);
					cmp_idx_s1 <= issue_q[IDX_W-1:0];
				end
				if (scan_hit) begin
					res_q.int_result <= INTERN_BASE + 32'(cmp_idx_s1);
					res_q.success    <= 1'b1;
				end else if (wr_en) begin
					res_q.int_result <= INTERN_BASE + 32'(fill_q);
					res_q.success    <= 1'b1;
				end
			end
			ST_RDW: begin
				res_q.handle_result <= rd_data;
				res_q.success       <= 1'b1;
			end
			ST_FIN: begin
				if (rsp_load) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// fill count stays within the table
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(SLOTS))
		else $error("fill count beyond table depth");

	// each append advances the fill count by one
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("append without fill count step");

	// an interned integer always names a filled slot
	a_rsp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.success && rsp.int_result[31:30] == 2'b01)
		|-> (rsp.int_result[29:0] < 30'(fill_q)))
		else $error("interned integer beyond fill count");

	// the memory is written only once the scan has finished
	a_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!cmp_vld_s1 && issue_q == fill_q))
		else $error("append before scan end");

endmodule

// ===== rtl/hit_ram.sv =====
// entry store: one write port, one registered read port
module hit_ram import hit_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF,
	parameter int unsigned IDX_W = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [63:0]      wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [63:0]      rd_data
);

	logic [63:0] mem [SLOTS];
	logic [63:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== verif/handle_intern_table_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the handle intern table
module handle_intern_table_tb;
	import hit_pkg::*;

	localparam int unsigned SLOTS = SLOTS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTED = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	handle_intern_table #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the table, its fill level and the passthrough range
	logic [63:0] shadow_entry [SLOTS];
	int          shadow_fill = 0;
	logic [15:0] range_low = PREDEF_LOW_RST;
	logic [15:0] range_high = PREDEF_HIGH_RST;

	req_t        lookup_queue [$];
	rsp_t        predicted_answers [$];
	logic [63:0] sent_handles [$];

	int  queued_reqs = 0;
	int  accepted_reqs = 0;
	int  answered = 0;
	int  err_count = 0;
	bit  req_taken = 1'b0;

	// what the run went through
	int  n_pass = 0, n_hit = 0, n_append = 0, n_full = 0, n_slot_read = 0, n_reject = 0;
	int  n_settings = 1;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic in_range(logic [63:0] v);
		return v >= 64'(range_low) && v <= 64'(range_high);
	endfunction

	// expected answer for one request; interns the handle on a miss
	function automatic rsp_t intern_predict(req_t r);
		rsp_t        o;
		logic [31:0] ofs;
		bit          hit;
		o = '0;
		hit = 1'b0;
		if (r.mode == MODE_SERIALIZE) begin
			if (in_range(r.handle_bits)) begin
				o.int_result = r.handle_bits[31:0];
				o.success = 1'b1;
				n_pass++;
			end else if (r.handle_bits == 64'd0) begin
				n_reject++;
			end else begin
				for (int i = 0; i < shadow_fill; i++) begin
					if (!hit && shadow_entry[i] == r.handle_bits) begin
						hit = 1'b1;
						o.int_result = INTERN_BASE + 32'(i);
						o.success = 1'b1;
					end
				end
				if (hit) begin
					n_hit++;
				end else if (shadow_fill < SLOTS) begin
					shadow_entry[shadow_fill] = r.handle_bits;
					o.int_result = INTERN_BASE + 32'(shadow_fill);
					o.success = 1'b1;
					shadow_fill++;
					n_append++;
				end else begin
					n_full++;
				end
			end
		end else begin
			ofs = r.int_value - INTERN_BASE;
			if (!r.int_value[31] && in_range({32'd0, r.int_value})) begin
				o.handle_result = {32'd0, r.int_value};
				o.success = 1'b1;
				n_pass++;
			end else if (!r.int_value[31] && ofs < SLOTS && int'(ofs) < shadow_fill) begin
				o.handle_result = shadow_entry[ofs];
				o.success = 1'b1;
				n_slot_read++;
			end else begin
				n_reject++;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("mismatch at %0t ns, response %0d: %s", $time, answered, what);
	endtask

	task automatic check_answer(input rsp_t got, input rsp_t want);
		if (got.int_result !== want.int_result)
			report_mismatch($sformatf("int_result %h, expected %h",
				got.int_result, want.int_result));
		if (got.handle_result !== want.handle_result)
			report_mismatch($sformatf("handle_result %h, expected %h",
				got.handle_result, want.handle_result));
		if (got.success !== want.success)
			report_mismatch($sformatf("success %b, expected %b", got.success, want.success));
	endtask

	function automatic req_t ser_item(logic [63:0] h);
		req_t r;
		r.mode = MODE_SERIALIZE;
		r.handle_bits = h;
		r.int_value = $urandom;
		return r;
	endfunction

	function automatic req_t des_item(logic [31:0] v);
		req_t r;
		r.mode = MODE_DESERIALIZE;
		r.handle_bits = {$urandom, $urandom};
		r.int_value = v;
		return r;
	endfunction

	// new random handle in several shapes, recorded so that later requests can repeat it
	function automatic logic [63:0] fresh_handle();
		logic [63:0] h;
		case ($urandom_range(0, 9))
			0: h = 64'($urandom_range(0, 65535));
			1: h = 64'd1 << $urandom_range(0, 63);
			2: h = ~(64'd1 << $urandom_range(0, 63));
			default: h = {$urandom, $urandom};
		endcase
		sent_handles.push_back(h);
		return h;
	endfunction

	// serialize requests of fresh or repeated handles and deserialize requests, so the table fills and then overflows
	function automatic req_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 || sent_handles.size() == 0)
				return ser_item(fresh_handle());
			else if (pick < 75)
				return ser_item(sent_handles[$urandom_range(0, sent_handles.size() - 1)]);
			else if (pick < 82)
				return ser_item(64'($urandom_range(0, 1000)));
			else if (pick < 87)
				case ($urandom_range(0, 3))
					0: return ser_item(64'(range_low) - 64'd1);
					1: return ser_item(64'(range_low));
					2: return ser_item(64'(range_high));
					default: return ser_item(64'(range_high) + 64'd1);
				endcase
			else if (pick < 92)
				return ser_item(64'd0);
			else
				return ser_item({$urandom, $urandom});
		end
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return des_item(INTERN_BASE + $urandom_range(0, SLOTS - 1));
		else if (pick < 58)
			return des_item($urandom_range(0, 1000));
		else if (pick < 65)
			case ($urandom_range(0, 4))
				0: return des_item(32'(range_low));
				1: return des_item(32'(range_high));
				2: return des_item(32'd0);
				3: return des_item(32'd65535);
				default: return des_item(32'd65536);
			endcase
		else if (pick < 70)
			return des_item(INTERN_BASE + SLOTS + $urandom_range(0, 40));
		else if (pick < 75)
			return des_item(INTERN_BASE - 32'd1 - $urandom_range(0, 40));
		else if (pick < 85)
			return des_item(32'h8000_0000 | $urandom);
		else
			return des_item($urandom);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PREDEF_LOW)
			range_low = val;
		else
			range_high = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// set the range if asked, queue a batch and wait until every answer has come back
	task automatic run_phase(input bit set_range, input logic [15:0] lo, input logic [15:0] hi,
			input int n);
		if (set_range) begin
			write_reg(REG_PREDEF_LOW, lo);
			write_reg(REG_PREDEF_HIGH, hi);
			n_settings++;
		end
		for (int i = 0; i < n; i++) begin
			lookup_queue.push_back(random_item());
			queued_reqs++;
		end
		while (accepted_reqs != queued_reqs || predicted_answers.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_directed(input req_t r);
		lookup_queue.push_back(r);
		queued_reqs++;
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (lookup_queue.size() > 0) begin
				req <= lookup_queue.pop_front();
				req_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: changing stall styles plus an occasional long hold-off
	int hold_left = 0;
	int next_hold_at = 700;
	int style_left = 0;
	int stall_style = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (accepted_reqs >= next_hold_at) begin
			hold_left = HOLD_CYCLES;
			next_hold_at += 700;
			rsp_stall <= 1'b1;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(50, 250);
			end
			style_left--;
			case (stall_style)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= style_left[0];
			endcase
		end
	end

	// monitor: predict on request transactions, check response transactions
	always @(posedge clk) begin
		req_taken = req_valid && !req_stall;
		if (req_taken) begin
			predicted_answers.push_back(intern_predict(req));
			accepted_reqs++;
		end
		if (rsp_valid && !rsp_stall) begin
			if (predicted_answers.size() == 0)
				report_mismatch("response with nothing outstanding");
			else
				check_answer(rsp, predicted_answers.pop_front());
			answered++;
		end
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("handle_intern_table_tb: done, errors");
			$finish;
		end
	end

	// main sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: range edges, zero handle, hits, misses, empty and bad slots
		push_directed(ser_item(64'd0));
		push_directed(ser_item(64'd32));
		push_directed(ser_item(64'd747));
		push_directed(ser_item(64'd31));
		push_directed(ser_item(64'd748));
		push_directed(ser_item(64'hffff_ffff_ffff_ffff));
		push_directed(ser_item(64'h8000_0000_0000_0000));
		push_directed(ser_item(64'd31));
		push_directed(ser_item(64'hffff_ffff_ffff_ffff));
		push_directed(ser_item(64'h0000_0001_0000_0020));
		push_directed(des_item(INTERN_BASE));
		push_directed(des_item(INTERN_BASE + 32'd3));
		push_directed(des_item(INTERN_BASE + 32'd5));
		push_directed(des_item(INTERN_BASE + SLOTS - 1));
		push_directed(des_item(INTERN_BASE + SLOTS));
		push_directed(des_item(INTERN_BASE - 32'd1));
		push_directed(des_item(32'hffff_ffff));
		push_directed(des_item(32'h8000_0000));
		push_directed(des_item(32'h7fff_ffff));
		push_directed(des_item(32'd32));
		push_directed(des_item(32'd747));
		push_directed(des_item(32'd0));
		push_directed(des_item(32'd31));
		sent_handles.push_back(64'd31);
		sent_handles.push_back(64'hffff_ffff_ffff_ffff);

		// random phases over several passthrough ranges
		run_phase(1'b0, 16'd0, 16'd0, 500);
		run_phase(1'b1, 16'h0000, 16'hffff, 250);
		run_phase(1'b1, 16'hffff, 16'h0000, 300);
		run_phase(1'b1, 16'h0000, 16'h0000, 200);
		run_phase(1'b1, 16'hffff, 16'hffff, 200);
		run_phase(1'b1, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)), 400);

		repeat (SLOTS + 8) @(posedge clk);
		$display("covered %0d requests over %0d range settings, %0d responses checked",
			accepted_reqs, n_settings, answered);
		$display("passthrough %0d, hits %0d, appends %0d, table full %0d, slot reads %0d, rejects %0d",
			n_pass, n_hit, n_append, n_full, n_slot_read, n_reject);
		if (err_count == 0 && predicted_answers.size() == 0) begin
			$display("handle_intern_table_tb: done, clean");
		end else begin
			if (predicted_answers.size() != 0)
				$display("%0d responses never arrived", predicted_answers.size());
			$display("handle_intern_table_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hit_pkg.sv
rtl/hit_ram.sv
rtl/handle_intern_table.sv
verif/handle_intern_table_tb.sv
